FILE: rtl/core/nmsp_pkg.sv
`default_nettype none

package nmsp_pkg;

  // Size limits and default build sizes
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int IDX_W        = 6;
  localparam int BITMAP_MAX   = 64;
  localparam int CNT_W        = 12;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_EMIT  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 2'd1;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] pattern_row;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/nmsp_row_store.sv
`default_nettype none

// Row bitmap store: one word per row, registered read, per-row valid bits
// so that reset and clear take effect at once. Invalid rows read as zero.
module nmsp_row_store #(
  parameter int ROWS = 64,
  parameter int BW   = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    clr,
  input  wire logic [$clog2(ROWS)-1:0] rd_addr,
  output logic      [BW-1:0]           rd_data,
  input  wire logic                    wr_en,
  input  wire logic [$clog2(ROWS)-1:0] wr_addr,
  input  wire logic [BW-1:0]           wr_data
);

  logic [BW-1:0]   mem [ROWS];
  logic [BW-1:0]   mem_q;
  logic            vld_q;
  logic [ROWS-1:0] vld_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_q <= vld_r[rd_addr];
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/normal_matrix_symbolic_pattern_core.sv
`default_nettype none

// Symbolic lower-triangle pattern of A*At. A load reads, then writes back
// the row word; a clear acts at once. An emit for row i first reads row i;
// then, unless a hit waits on a stalled result side, the scan reads one
// later row per cycle through the single read port of the row store and
// tests it against row i. The input side stalls while a load or an emit is
// in progress; the last result of an emit sits in the output register while
// the next item is taken.
module normal_matrix_symbolic_pattern_core
  import nmsp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int BW    = (MAX_COLS < BITMAP_MAX) ? MAX_COLS : BITMAP_MAX;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_EM_BASE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] act_rows_r, act_cols_r;
  logic [CFG_W-1:0] rows_lim, cols_lim;
  logic [CFG_W-1:0] j_r, j_nxt, j_inc;
  logic [BW-1:0]    base_r, base_nxt;
  logic [IDX_W-1:0] pend_r, pend_nxt;
  logic [ROW_W-1:0] ld_row_r, ld_row_nxt;
  logic [IDX_W-1:0] ld_col_r, ld_col_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_inc;

  logic [BW-1:0]    col_mask, col_bit, rd_data, wr_data;
  logic [ROW_W-1:0] rd_addr;
  logic             wr_en, clr, accept, out_free, hit, push, push_last;
  logic [IDX_W-1:0] push_row;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_rows_r <= CFG_RESET;
      act_cols_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE_ROWS: act_rows_r <= cfg_data;
        CFG_ACTIVE_COLS: act_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective limits, saturated to the build sizes
  assign rows_lim = (act_rows_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : act_rows_r;
  assign cols_lim = (act_cols_r > CFG_W'(BW)) ? CFG_W'(BW) : act_cols_r;

  always_comb begin
    for (int k = 0; k < BW; k++) begin
      col_mask[k] = (CFG_W'(k) < cols_lim);
      col_bit[k]  = (ld_col_r == IDX_W'(k));
    end
  end

  // Row store
  assign wr_data = rd_data | col_bit;

  nmsp_row_store #(
    .ROWS (MAX_ROWS),
    .BW   (BW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ld_row_r),
    .wr_data (wr_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign hit       = |(base_r & rd_data);
  assign j_inc     = j_r + CFG_W'(1);
  assign count_inc = (count_r == CNT_MAX) ? count_r : count_r + CNT_W'(1);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    base_nxt   = base_r;
    pend_nxt   = pend_r;
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    count_nxt  = count_r;
    rd_addr    = j_r[ROW_W-1:0];
    wr_en      = 1'b0;
    clr        = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    push_row   = pend_r;

    case (state_r)
      ST_IDLE: begin
        rd_addr = in_data.row_index[ROW_W-1:0];
        if (accept) begin
          case (in_data.action)
            ACT_LOAD: begin
              if ({1'b0, in_data.row_index} < rows_lim &&
                  {1'b0, in_data.col_index} < cols_lim) begin
                ld_row_nxt = in_data.row_index[ROW_W-1:0];
                ld_col_nxt = in_data.col_index;
                state_nxt  = ST_LD_WR;
              end
            end
            ACT_EMIT: begin
              if ({1'b0, in_data.row_index} < rows_lim) begin
                pend_nxt  = in_data.row_index;
                state_nxt = ST_EM_BASE;
              end
            end
            ACT_CLEAR: begin
              clr       = 1'b1;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      ST_LD_WR: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_EM_BASE: begin
        base_nxt = rd_data & col_mask;
        j_nxt    = {1'b0, pend_r} + CFG_W'(1);
        rd_addr  = j_nxt[ROW_W-1:0];
        state_nxt = (j_nxt < rows_lim) ? ST_SCAN : ST_FLUSH;
      end

      ST_SCAN: begin
        // A hit hands the held entry out and holds row j in its place, once the output is free
        if (hit && out_free) begin
          push     = 1'b1;
          pend_nxt = j_r[IDX_W-1:0];
        end
        if (!hit || out_free) begin
          if (j_inc < rows_lim) begin
            j_nxt   = j_inc;
            rd_addr = j_inc[ROW_W-1:0];
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Output register
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (push) begin
      count_nxt                = count_inc;
      out_valid_nxt            = 1'b1;
      out_data_nxt.pattern_row = push_row;
      out_data_nxt.entry_count = count_inc;
      out_data_nxt.last        = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    pend_r     <= pend_nxt;
    ld_row_r   <= ld_row_nxt;
    ld_col_r   <= ld_col_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;
  import nmsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int REPORT_MAX     = 10;

  // Codes the package does not name
  localparam logic [1:0]           ACT_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  normal_matrix_symbolic_pattern_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the block state
  logic [BITMAP_MAX-1:0] nz_map [DEF_MAX_ROWS];
  logic [CNT_W-1:0]      entry_total = '0;
  logic [CFG_W-1:0]      rows_cfg    = CFG_RESET;
  logic [CFG_W-1:0]      cols_cfg    = CFG_RESET;
  out_item_t             pattern_q [$];

  int fail_count = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;

  initial begin
    foreach (nz_map[k]) nz_map[k] = '0;
  end

  function automatic int unsigned eff_lim(logic [CFG_W-1:0] v, int unsigned cap);
    return (v > cap) ? cap : v;
  endfunction

  // Shadow state update and expected pattern column for one accepted item
  function automatic void predict_pattern(in_item_t it);
    int unsigned rl, cl;
    logic [BITMAP_MAX-1:0] mask, base;
    out_item_t hits [$];
    out_item_t e;
    rl = eff_lim(rows_cfg, DEF_MAX_ROWS);
    cl = eff_lim(cols_cfg, BITMAP_MAX);
    mask = (cl >= BITMAP_MAX) ? '1 : ((64'd1 << cl) - 64'd1);
    case (it.action)
      ACT_LOAD: begin
        if (it.row_index < rl && it.col_index < cl)
          nz_map[it.row_index][it.col_index] = 1'b1;
      end
      ACT_CLEAR: begin
        foreach (nz_map[k]) nz_map[k] = '0;
        entry_total = '0;
      end
      ACT_EMIT: begin
        if (it.row_index < rl) begin
          base = nz_map[it.row_index] & mask;
          for (int j = it.row_index; j < rl; j++) begin
            // diagonal always present, later rows need a shared column
            if (j == it.row_index || (base & nz_map[j]) != '0) begin
              if (entry_total != CNT_MAX) entry_total++;
              e.pattern_row = 6'(j);
              e.entry_count = entry_total;
              e.last        = 1'b0;
              hits.push_back(e);
            end
          end
          hits[hits.size()-1].last = 1'b1;
          foreach (hits[k]) pattern_q.push_back(hits[k]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t item_of(logic [1:0] act, int r, int c);
    in_item_t it;
    it.action    = act;
    it.row_index = 6'(r);
    it.col_index = 6'(c);
    return it;
  endfunction

  // Mostly in-range loads and emits, some out-of-range noise, clears and undefined actions
  function automatic in_item_t gen_item();
    in_item_t it;
    int unsigned pick, rl, cl;
    rl = eff_lim(rows_cfg, DEF_MAX_ROWS);
    cl = eff_lim(cols_cfg, BITMAP_MAX);
    pick = $urandom_range(99);
    it.row_index = 6'($urandom);
    it.col_index = 6'($urandom);
    if (pick < 55) begin
      it.action = ACT_LOAD;
      if (rl > 0) it.row_index = 6'($urandom_range(rl - 1));
      if (cl > 0) begin
        // narrow column range half the time so rows overlap
        if ($urandom_range(1)) it.col_index = 6'($urandom_range(((cl < 8) ? cl : 8) - 1));
        else it.col_index = 6'($urandom_range(cl - 1));
      end
    end else if (pick < 85) begin
      it.action = ACT_EMIT;
      if (rl > 0) it.row_index = 6'($urandom_range(rl - 1));
    end else if (pick < 90) begin
      it.action = ACT_LOAD;
    end else if (pick < 94) begin
      it.action = ACT_EMIT;
    end else if (pick < 97) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  // One input transfer, with optional idle cycles ahead of it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_pattern(it);
  endtask

  // Stop sending and wait for every expected result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pattern_q.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ACTIVE_ROWS) rows_cfg = val;
    else if (idx == CFG_ACTIVE_COLS) cols_cfg = val;
  endtask

  task automatic configure(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    settle();
    write_reg(CFG_ACTIVE_ROWS, rows);
    write_reg(CFG_ACTIVE_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: long hold-off when requested, else random stall
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pattern_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("mismatch: unexpected result row=%0d count=%0d last=%0b",
                   out_data.pattern_row, out_data.entry_count, out_data.last);
      end else begin
        want = pattern_q.pop_front();
        if (out_data !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: got row=%0d count=%0d last=%0b, want row=%0d count=%0d last=%0b",
                     out_data.pattern_row, out_data.entry_count, out_data.last,
                     want.pattern_row, want.entry_count, want.last);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel
  wire any_transfer = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                      (cfg_valid && cfg_ready);

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || any_transfer) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Corner indexes, diagonal-only rows, undefined action, clear
  task automatic test_basic_pattern();
    idle_pct  = 0;
    stall_pct = 0;
    configure(7'd64, 7'd64);
    send_item(item_of(ACT_CLEAR, 0, 0));
    send_item(item_of(ACT_LOAD, 0, 0));
    send_item(item_of(ACT_LOAD, 63, 63));
    send_item(item_of(ACT_LOAD, 63, 0));
    send_item(item_of(ACT_LOAD, 5, 63));
    send_item(item_of(ACT_LOAD, 62, 42));
    send_item(item_of(ACT_LOAD, 21, 21));
    send_item(item_of(ACT_LOAD, 42, 21));
    send_item(item_of(ACT_EMIT, 0, 0));
    send_item(item_of(ACT_EMIT, 5, 63));
    send_item(item_of(ACT_EMIT, 63, 0));
    send_item(item_of(ACT_EMIT, 21, 42));
    send_item(item_of(ACT_NONE, 63, 63));
    send_item(item_of(ACT_EMIT, 62, 21));
    send_item(item_of(ACT_CLEAR, 63, 63));
    send_item(item_of(ACT_EMIT, 63, 63));
    drain();
  endtask

  // Out-of-range loads and emits, stale columns and rows past the limit
  task automatic test_size_limits();
    configure(7'd64, 7'd64);
    send_item(item_of(ACT_CLEAR, 0, 0));
    send_item(item_of(ACT_LOAD, 1, 40));
    send_item(item_of(ACT_LOAD, 2, 40));
    send_item(item_of(ACT_LOAD, 1, 0));
    send_item(item_of(ACT_LOAD, 9, 0));
    send_item(item_of(ACT_EMIT, 1, 0));
    configure(7'd9, 7'd1);
    send_item(item_of(ACT_EMIT, 1, 0));
    send_item(item_of(ACT_LOAD, 3, 1));
    send_item(item_of(ACT_LOAD, 9, 0));
    send_item(item_of(ACT_LOAD, 3, 0));
    send_item(item_of(ACT_EMIT, 1, 0));
    send_item(item_of(ACT_EMIT, 9, 0));
    send_item(item_of(ACT_EMIT, 8, 0));
    drain();
  endtask

  // Zero, saturating and spare register writes
  task automatic test_register_extremes();
    configure(7'd0, 7'd0);
    send_item(item_of(ACT_LOAD, 0, 0));
    send_item(item_of(ACT_EMIT, 0, 0));
    configure(7'd127, 7'd127);
    send_item(item_of(ACT_LOAD, 63, 63));
    send_item(item_of(ACT_LOAD, 0, 63));
    send_item(item_of(ACT_EMIT, 0, 0));
    settle();
    write_reg(CFG_SPARE_2, 7'h55);
    write_reg(CFG_SPARE_3, 7'h2a);
    cfg_valid <= 1'b0;
    send_item(item_of(ACT_EMIT, 0, 0));
    configure(7'd1, 7'd64);
    send_item(item_of(ACT_EMIT, 0, 0));
    send_item(item_of(ACT_EMIT, 1, 0));
    configure(7'd64, 7'd1);
    send_item(item_of(ACT_EMIT, 0, 0));
    drain();
  endtask

  // Full-length columns until the entry count saturates
  task automatic test_count_saturation();
    idle_pct  = 0;
    stall_pct = 0;
    configure(7'd64, 7'd64);
    send_item(item_of(ACT_CLEAR, 0, 0));
    for (int r = 0; r < DEF_MAX_ROWS; r++) send_item(item_of(ACT_LOAD, r, 0));
    for (int k = 0; k < 65; k++) send_item(item_of(ACT_EMIT, 0, 0));
    send_item(item_of(ACT_EMIT, 63, 0));
    send_item(item_of(ACT_CLEAR, 0, 0));
    send_item(item_of(ACT_EMIT, 0, 0));
    drain();
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_output_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    configure(7'd64, 7'd64);
    send_item(item_of(ACT_CLEAR, 0, 0));
    for (int r = 0; r < 12; r++) send_item(item_of(ACT_LOAD, r, r % 3));
    hold_left = HOLD_CYCLES;
    for (int k = 0; k < 14; k++) send_item(item_of(ACT_EMIT, k % 6, 0));
    // sender waits until the backlog is gone
    drain();
    stall_pct = 30;
    for (int k = 0; k < 4; k++) send_item(item_of(ACT_EMIT, k, 0));
    drain();
  endtask

  task automatic test_random_traffic(int n, int in_idle, int out_stall_pct,
                                     logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    configure(rows, cols);
    idle_pct  = in_idle;
    stall_pct = out_stall_pct;
    send_item(item_of(ACT_CLEAR, 0, 0));
    for (int k = 0; k < n; k++) send_item(gen_item());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_pattern();
    test_size_limits();
    test_register_extremes();
    test_count_saturation();
    test_output_holdoff();
    test_random_traffic(50, 0, 0, 7'd64, 7'd64);
    test_random_traffic(50, 65, 0, 7'd16, 7'd8);
    test_random_traffic(50, 0, 65, 7'($urandom_range(1, 64)), 7'd3);
    test_random_traffic(50, 11, 11, 7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pattern_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: normal_matrix_symbolic_pattern_core.f
rtl/core/nmsp_pkg.sv
rtl/core/nmsp_row_store.sv
rtl/core/normal_matrix_symbolic_pattern_core.sv
dv/tb_top.sv
